// ----- design/rte_pkg.sv -----
// types, constants and helpers for the retransmit timeout estimator
// used by design/retransmit_timeout_estimator.sv and design/rte_checker.sv
`timescale 1ns / 1ps
`default_nettype none

package rte_pkg;

  localparam int unsigned RTT_W  = 15;
  localparam int unsigned DEV_W  = 16;
  localparam int unsigned RTO_W  = 10;
  localparam int unsigned ADDR_W = 3;
  localparam int unsigned DATA_W = 32;

  localparam logic [RTT_W-1:0] INIT_RTT        = 15'd240;
  localparam logic [DEV_W-1:0] INIT_DEV        = 16'd240;
  localparam logic [RTO_W-1:0] INIT_RETRANSMIT = 10'd480;
  localparam logic [RTO_W-1:0] MAX_RETRANSMIT  = 10'd960;

  localparam int unsigned AVG_SHIFT     = 6;
  localparam int unsigned DEV_SHIFT     = 4;
  localparam int unsigned EXTREME_SHIFT = 5;

  // request operation codes
  localparam logic OP_SAMPLE  = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  // register index, taken from paddr bit 2
  localparam logic REG_MIN_RETRANSMIT = 1'b0;

  typedef struct packed {
    logic             op;
    logic [RTT_W-1:0] round_trip_sample;
    logic             first_sample;
  } rte_in_t;

  typedef struct packed {
    logic [RTO_W-1:0] retransmit_ticks;
    logic [RTT_W-1:0] average_rtt;
    logic [RTT_W-1:0] filtered_rtt;
    logic [RTT_W-1:0] pessimist_rtt;
    logic [RTT_W-1:0] optimist_rtt;
    logic [DEV_W-1:0] rtt_deviation;
  } rte_out_t;

  // moving average (old * (2^k - 1) + sample) >> k, k a constant at each call
  function automatic logic [DEV_W-1:0] smooth(input logic [DEV_W-1:0] old_val,
                                              input logic [DEV_W-1:0] smp,
                                              input int unsigned k);
    logic [21:0] acc;
    logic [21:0] shr;
    acc = ({6'd0, old_val} << k) - {6'd0, old_val} + {6'd0, smp};
    shr = acc >> k;
    return shr[DEV_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- design/retransmit_timeout_estimator.sv -----
// retransmit timeout estimator top level: request register, estimate update, result register
// depends on rte_pkg
`timescale 1ns / 1ps
`default_nettype none

// Takes one request per cycle while in_stall is low: a round-trip sample (op 0) or
// a restart (op 1). A sample updates the smoothed average (1/64), the pessimist or
// optimist (1/32, picked by comparing the sample with the average), the filtered rtt
// (1/64, only for samples near the optimist) and the deviation (1/16, from twice the
// distance to the optimist), then derives the retransmit time, raised to
// min_retransmit or clamped to 960. A first-sample request only sets the four rtt
// estimates to the sample, and only when it is below the average. Every request
// gives exactly one result carrying the estimates after its update. An accepted
// request passes the request register and then the result register, where
// out_valid shows it; the estimate update between them reads and writes the state
// registers, and out_stall can hold a request in the request register. in_stall
// rises only when both the request register and the result register are full and
// out_stall is high. min_retransmit sits at byte address 0 of the config port;
// only paddr[2] is decoded and writes to address 4 are dropped.

module retransmit_timeout_estimator (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_stall,
  input  wire  rte_pkg::rte_in_t       in_data,
  output logic                         out_valid,
  input  wire                          out_stall,
  output rte_pkg::rte_out_t            out_data,
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire  [rte_pkg::ADDR_W-1:0]   paddr,
  input  wire  [rte_pkg::DATA_W-1:0]   pwdata,
  output logic [rte_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);

  // config register
  logic [rte_pkg::RTO_W-1:0] min_rto_r;

  // request register stage
  logic             req_valid_r;
  rte_pkg::rte_in_t req_r;

  // estimator state
  logic [rte_pkg::RTT_W-1:0] avg_r, filt_r, pes_r, opt_r;
  logic [rte_pkg::DEV_W-1:0] dev_r;
  logic [rte_pkg::RTO_W-1:0] rto_r;

  logic [rte_pkg::RTT_W-1:0] avg_nxt, filt_nxt, pes_nxt, opt_nxt;
  logic [rte_pkg::DEV_W-1:0] dev_nxt;
  logic [rte_pkg::RTO_W-1:0] rto_nxt;

  logic out_valid_r;
  rte_pkg::rte_out_t out_r;

  logic load;     // request register moves into state and result register
  logic accept;
  logic cfg_wr;

  // update datapath
  logic [rte_pkg::RTT_W-1:0] rtt;
  logic                      above_avg;
  logic [rte_pkg::DEV_W-1:0] pes_sm, opt_sm, avg_sm, filt_sm, dev_sm;
  logic [rte_pkg::RTT_W-1:0] opt_new, avg_new, filt_new;
  logic [rte_pkg::DEV_W-1:0] dev_new;
  logic signed [16:0]        diff;
  logic [16:0]               thr_sum;
  logic [rte_pkg::DEV_W-1:0] mag;
  logic [16:0]               mean_sum;
  logic [16:0]               rto_sum;
  logic [rte_pkg::RTO_W-1:0] rto_new;

  assign load     = !out_valid_r || !out_stall;
  assign in_stall = req_valid_r && !load;
  assign accept   = in_valid && !in_stall;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == rte_pkg::REG_MIN_RETRANSMIT)
                  ? {{(rte_pkg::DATA_W-rte_pkg::RTO_W){1'b0}}, min_rto_r}
                  : '0;

  always_comb begin
    rtt       = req_r.round_trip_sample;
    above_avg = rtt > avg_r;

    pes_sm  = rte_pkg::smooth({1'b0, pes_r}, {1'b0, rtt}, rte_pkg::EXTREME_SHIFT);
    opt_sm  = rte_pkg::smooth({1'b0, opt_r}, {1'b0, rtt}, rte_pkg::EXTREME_SHIFT);
    avg_sm  = rte_pkg::smooth({1'b0, avg_r}, {1'b0, rtt}, rte_pkg::AVG_SHIFT);
    filt_sm = rte_pkg::smooth({1'b0, filt_r}, {1'b0, rtt}, rte_pkg::AVG_SHIFT);

    opt_new = above_avg ? opt_r : opt_sm[rte_pkg::RTT_W-1:0];
    avg_new = avg_sm[rte_pkg::RTT_W-1:0];

    // signed distance from the freshly updated optimist
    diff    = $signed({2'b00, rtt}) - $signed({2'b00, opt_new});
    thr_sum = {2'b00, opt_new} + {1'b0, dev_r};
    filt_new = (diff <= $signed({2'b00, thr_sum[16:2]})) ? filt_sm[rte_pkg::RTT_W-1:0]
                                                         : filt_r;

    mag    = diff[16] ? 16'(-diff) : diff[15:0];
    dev_sm = rte_pkg::smooth(dev_r, {mag[14:0], 1'b0}, rte_pkg::DEV_SHIFT);
    // far samples leave the deviation alone
    dev_new = (mag <= {1'b0, opt_new}) ? dev_sm : dev_r;

    mean_sum = {1'b0, filt_new, 1'b0} + {2'b00, avg_new};
    rto_sum  = {1'b0, mean_sum[16:1]} + {1'b0, dev_new};
    priority if (rto_sum < {7'd0, min_rto_r}) begin
      rto_new = min_rto_r;
    end else if (rto_sum > {7'd0, rte_pkg::MAX_RETRANSMIT}) begin
      rto_new = rte_pkg::MAX_RETRANSMIT;
    end else begin
      rto_new = rto_sum[rte_pkg::RTO_W-1:0];
    end

    avg_nxt  = avg_r;
    filt_nxt = filt_r;
    pes_nxt  = pes_r;
    opt_nxt  = opt_r;
    dev_nxt  = dev_r;
    rto_nxt  = rto_r;
    priority if (req_r.op == rte_pkg::OP_RESTART) begin
      avg_nxt  = rte_pkg::INIT_RTT;
      filt_nxt = rte_pkg::INIT_RTT;
      pes_nxt  = rte_pkg::INIT_RTT;
      opt_nxt  = rte_pkg::INIT_RTT;
      dev_nxt  = rte_pkg::INIT_DEV;
      rto_nxt  = rte_pkg::INIT_RETRANSMIT;
    end else if (req_r.first_sample) begin
      // first ack only sets the rtt estimates to a sample below the average
      if (rtt < avg_r) begin
        avg_nxt  = rtt;
        filt_nxt = rtt;
        pes_nxt  = rtt;
        opt_nxt  = rtt;
      end
    end else begin
      avg_nxt  = avg_new;
      filt_nxt = filt_new;
      pes_nxt  = above_avg ? pes_sm[rte_pkg::RTT_W-1:0] : pes_r;
      opt_nxt  = opt_new;
      dev_nxt  = dev_new;
      rto_nxt  = rto_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_rto_r   <= '0;
      req_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      avg_r       <= rte_pkg::INIT_RTT;
      filt_r      <= rte_pkg::INIT_RTT;
      pes_r       <= rte_pkg::INIT_RTT;
      opt_r       <= rte_pkg::INIT_RTT;
      dev_r       <= rte_pkg::INIT_DEV;
      rto_r       <= rte_pkg::INIT_RETRANSMIT;
    end else begin
      if (cfg_wr && (paddr[2] == rte_pkg::REG_MIN_RETRANSMIT)) begin
        min_rto_r <= pwdata[rte_pkg::RTO_W-1:0];
      end
      if (!in_stall) begin
        req_valid_r <= in_valid;
      end
      if (load) begin
        out_valid_r <= req_valid_r;
        if (req_valid_r) begin
          avg_r  <= avg_nxt;
          filt_r <= filt_nxt;
          pes_r  <= pes_nxt;
          opt_r  <= opt_nxt;
          dev_r  <= dev_nxt;
          rto_r  <= rto_nxt;
        end
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_data;
    end
    if (load && req_valid_r) begin
      out_r.retransmit_ticks <= rto_nxt;
      out_r.average_rtt      <= avg_nxt;
      out_r.filtered_rtt     <= filt_nxt;
      out_r.pessimist_rtt    <= pes_nxt;
      out_r.optimist_rtt     <= opt_nxt;
      out_r.rtt_deviation    <= dev_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

// ----- design/rte_checker.sv -----
// port-level checks for the retransmit timeout estimator, bound to its top level
// depends on rte_pkg and retransmit_timeout_estimator
`timescale 1ns / 1ps
`default_nettype none

module rte_checker (
  input wire                    clk,
  input wire                    rst_n,
  input wire                    in_valid,
  input wire                    in_stall,
  input wire                    out_valid,
  input wire                    out_stall,
  input wire rte_pkg::rte_out_t out_data
);

  // a stalled result stays up
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result does not change
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("result changed while stalled");

  // an empty result register never backs up the request side
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("request stalled with empty result register");

  // an accepted request reaches the result register through the request register unless out_stall holds it
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) ##1 !out_stall |=> out_valid)
    else $error("accepted request did not reach the result register");

endmodule

bind retransmit_timeout_estimator rte_checker u_rte_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
